// File: hdl/assert_macros.svh
// assertion helpers included by range_distinct_count_unit.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define RDC_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define RDC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define RDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/rdc_pkg.sv
package rdc_pkg;

  // item field widths
  localparam int OPCODE_W = 1;
  localparam int IDX_W    = 10;
  localparam int VAL_W    = 10;
  localparam int TAG_W    = 16;
  localparam int CNT_W    = 11;

  // default store sizes
  localparam int DEF_ELEMENT_DEPTH = 1024;
  localparam int DEF_VALUE_COUNT   = 1024;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_WRITE = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_QUERY = 1'b1;

endpackage

// File: hdl/rdc_in_if.sv
interface rdc_in_if;
  logic                         valid;
  logic                         ready;
  logic [rdc_pkg::OPCODE_W-1:0] opcode;
  logic [rdc_pkg::IDX_W-1:0]    elem_index;
  logic [rdc_pkg::VAL_W-1:0]    elem_value;
  logic [rdc_pkg::IDX_W-1:0]    range_left;
  logic [rdc_pkg::IDX_W-1:0]    range_right;
  logic [rdc_pkg::TAG_W-1:0]    query_tag;

  modport source (
    output valid, opcode, elem_index, elem_value, range_left, range_right, query_tag,
    input  ready
  );

  modport sink (
    input  valid, opcode, elem_index, elem_value, range_left, range_right, query_tag,
    output ready
  );
endinterface

// File: hdl/rdc_out_if.sv
interface rdc_out_if;
  logic                      valid;
  logic                      ready;
  logic [rdc_pkg::CNT_W-1:0] distinct_count;
  logic [rdc_pkg::TAG_W-1:0] answer_tag;
  logic                      bad_range;

  modport source (
    output valid, distinct_count, answer_tag, bad_range,
    input  ready
  );

  modport sink (
    input  valid, distinct_count, answer_tag, bad_range,
    output ready
  );
endinterface

// File: hdl/range_distinct_count_unit.sv
// distinct-value counter over a sliding window of an element store
// in_ch takes write items (opcode 0) and range queries (opcode 1) by valid/ready.
// out_ch returns one item per query: distinct count, the query tag, bad_range flag.
// a write returns nothing; a write outside the window is stored directly, a write
// inside the window reads the old value, drops it, stores the new one and counts
// it in. a query moves the window by single positions until it covers the range;
// each move is one element store read, one frequency table read and at most one
// frequency write; both memories are synchronous with a read and a write port.
// a rejected query (left above right, or right past the store) skips every move.
// one item is worked on at a time; in_ch.ready is high only between items.
// results sit in an output register, so the next item is taken while a result
// waits; a query that finishes while that register is still full waits for it.
// after reset the block sweeps both memories to zero, one entry per cycle, over
// max(ELEMENT_DEPTH, VALUE_COUNT) addresses; in_ch.ready stays low during that pass.
`include "assert_macros.svh"

module range_distinct_count_unit #(
  parameter int ELEMENT_DEPTH = rdc_pkg::DEF_ELEMENT_DEPTH,
  parameter int VALUE_COUNT   = rdc_pkg::DEF_VALUE_COUNT
) (
  input  logic      clk,
  input  logic      rst_n,
  rdc_in_if.sink    in_ch,
  rdc_out_if.source out_ch
);

  localparam int AW   = $clog2(ELEMENT_DEPTH);
  localparam int PW   = $clog2(ELEMENT_DEPTH + 1);
  localparam int VW   = $clog2(VALUE_COUNT);
  localparam int XW   = (PW > rdc_pkg::IDX_W ? PW : rdc_pkg::IDX_W) + 1;
  localparam int VX   = (VW > rdc_pkg::VAL_W ? VW : rdc_pkg::VAL_W) + 1;
  localparam int MAXD = (ELEMENT_DEPTH > VALUE_COUNT) ? ELEMENT_DEPTH : VALUE_COUNT;
  localparam int CLW  = $clog2(MAXD);
  localparam int OX   = (PW > rdc_pkg::CNT_W) ? PW : rdc_pkg::CNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_QSTEP = 3'd2;
  localparam logic [2:0] S_VREAD = 3'd3;
  localparam logic [2:0] S_FUPD  = 3'd4;
  localparam logic [2:0] S_WADD  = 3'd5;

  logic [2:0]                 state_r, state_nxt;
  logic [CLW-1:0]             clr_r, clr_nxt;
  logic [PW-1:0]              ws_r, ws_nxt;
  logic [PW-1:0]              we_r, we_nxt;
  logic [PW-1:0]              total_r, total_nxt;
  logic [PW-1:0]              lft_r, lft_nxt;
  logic [PW-1:0]              end_r, end_nxt;
  logic                       bad_r, bad_nxt;
  logic                       qry_r, qry_nxt;
  logic                       add_r, add_nxt;
  logic [rdc_pkg::TAG_W-1:0]  tag_r, tag_nxt;
  logic [AW-1:0]              idx_r, idx_nxt;
  logic [VW-1:0]              val_r, val_nxt;
  logic [VW-1:0]              v_r, v_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [rdc_pkg::CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [rdc_pkg::TAG_W-1:0]  out_tag_r, out_tag_nxt;
  logic                       out_bad_r, out_bad_nxt;

  // memories and their ports
  logic [VW-1:0] elem_mem [ELEMENT_DEPTH];
  logic [PW-1:0] freq_mem [VALUE_COUNT];
  logic          elem_we;
  logic [AW-1:0] elem_waddr, elem_raddr;
  logic [VW-1:0] elem_wdata, elem_rdata_r;
  logic          freq_we;
  logic [VW-1:0] freq_waddr, freq_raddr;
  logic [PW-1:0] freq_wdata, freq_rdata_r;

  // input decode
  logic [XW-1:0] in_idx_x, in_l_x, in_r_x, in_e_x;
  logic [VX-1:0] in_val_x;
  logic          in_fire, wr_ok, wr_inside, q_bad;

  // window move decode
  logic          mv_any, mv_add;
  logic [PW-1:0] mv_pos, mv_ws, mv_we;

  // clear sweep decode
  logic          clr_elem, clr_freq, clr_last;

  // out slot free
  logic          out_free;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign in_idx_x  = XW'(in_ch.elem_index);
  assign in_l_x    = XW'(in_ch.range_left);
  assign in_r_x    = XW'(in_ch.range_right);
  assign in_e_x    = in_r_x + XW'(1);
  assign in_val_x  = VX'(in_ch.elem_value);
  assign wr_ok     = (in_idx_x < XW'(ELEMENT_DEPTH)) && (in_val_x < VX'(VALUE_COUNT));
  assign wr_inside = (in_idx_x >= XW'(ws_r)) && (in_idx_x < XW'(we_r));
  assign q_bad     = (in_l_x > in_r_x) || (in_r_x >= XW'(ELEMENT_DEPTH));

  assign clr_elem = ({1'b0, clr_r} < (CLW + 1)'(ELEMENT_DEPTH));
  assign clr_freq = ({1'b0, clr_r} < (CLW + 1)'(VALUE_COUNT));
  assign clr_last = ({1'b0, clr_r} == (CLW + 1)'(MAXD - 1));

  assign out_free = !out_valid_r || out_ch.ready;

  // next window move: grow left, grow right, shrink left, shrink right
  always_comb begin
    mv_any = 1'b1;
    mv_add = 1'b1;
    mv_pos = ws_r;
    mv_ws  = ws_r;
    mv_we  = we_r;
    if (ws_r > lft_r) begin
      mv_pos = ws_r - PW'(1);
      mv_ws  = ws_r - PW'(1);
    end else if (we_r < end_r) begin
      mv_pos = we_r;
      mv_we  = we_r + PW'(1);
    end else if (ws_r < lft_r) begin
      mv_add = 1'b0;
      mv_pos = ws_r;
      mv_ws  = ws_r + PW'(1);
    end else if (we_r > end_r) begin
      mv_add = 1'b0;
      mv_pos = we_r - PW'(1);
      mv_we  = we_r - PW'(1);
    end else begin
      mv_any = 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    ws_nxt        = ws_r;
    we_nxt        = we_r;
    total_nxt     = total_r;
    lft_nxt       = lft_r;
    end_nxt       = end_r;
    bad_nxt       = bad_r;
    qry_nxt       = qry_r;
    add_nxt       = add_r;
    tag_nxt       = tag_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    v_nxt         = v_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_cnt_nxt   = out_cnt_r;
    out_tag_nxt   = out_tag_r;
    out_bad_nxt   = out_bad_r;
    elem_we       = 1'b0;
    elem_waddr    = idx_r;
    elem_wdata    = val_r;
    elem_raddr    = in_idx_x[AW-1:0];
    freq_we       = 1'b0;
    freq_waddr    = v_r;
    freq_wdata    = freq_rdata_r;
    freq_raddr    = v_r;

    case (state_r)
      S_CLEAR: begin
        elem_we    = clr_elem;
        elem_waddr = clr_r[AW-1:0];
        elem_wdata = '0;
        freq_we    = clr_freq;
        freq_waddr = clr_r[VW-1:0];
        freq_wdata = '0;
        clr_nxt    = clr_r + CLW'(1);
        if (clr_last) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.opcode == rdc_pkg::OP_QUERY) begin
            qry_nxt   = 1'b1;
            bad_nxt   = q_bad;
            lft_nxt   = in_l_x[PW-1:0];
            end_nxt   = in_e_x[PW-1:0];
            tag_nxt   = in_ch.query_tag;
            state_nxt = S_QSTEP;
          end else if (wr_ok) begin
            if (wr_inside) begin
              // old value leaves the window first; its read is issued now
              qry_nxt   = 1'b0;
              add_nxt   = 1'b0;
              idx_nxt   = in_idx_x[AW-1:0];
              val_nxt   = in_val_x[VW-1:0];
              state_nxt = S_VREAD;
            end else begin
              elem_we    = 1'b1;
              elem_waddr = in_idx_x[AW-1:0];
              elem_wdata = in_val_x[VW-1:0];
            end
          end
        end
      end

      S_QSTEP: begin
        if (bad_r || !mv_any) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_cnt_nxt   = bad_r ? '0 : rdc_pkg::CNT_W'(OX'(total_r));
            out_tag_nxt   = tag_r;
            out_bad_nxt   = bad_r;
            state_nxt     = S_IDLE;
          end
        end else begin
          elem_raddr = mv_pos[AW-1:0];
          add_nxt    = mv_add;
          ws_nxt     = mv_ws;
          we_nxt     = mv_we;
          state_nxt  = S_VREAD;
        end
      end

      S_VREAD: begin
        v_nxt      = elem_rdata_r;
        freq_raddr = elem_rdata_r;
        state_nxt  = S_FUPD;
      end

      S_FUPD: begin
        // read-modify-write of one frequency entry
        if (add_r) begin
          freq_we    = 1'b1;
          freq_wdata = freq_rdata_r + PW'(1);
          if (freq_rdata_r == '0) begin
            total_nxt = total_r + PW'(1);
          end
        end else if (freq_rdata_r != '0) begin
          freq_we    = 1'b1;
          freq_wdata = freq_rdata_r - PW'(1);
          if ((freq_rdata_r == PW'(1)) && (total_r != '0)) begin
            total_nxt = total_r - PW'(1);
          end
        end
        if (qry_r) begin
          state_nxt = S_QSTEP;
        end else if (!add_r) begin
          // in-window write: store new value, then count it in
          elem_we   = 1'b1;
          state_nxt = S_WADD;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_WADD: begin
        freq_raddr = val_r;
        v_nxt      = val_r;
        add_nxt    = 1'b1;
        state_nxt  = S_FUPD;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // element store
  always_ff @(posedge clk) begin
    if (elem_we) begin
      elem_mem[elem_waddr] <= elem_wdata;
    end
    elem_rdata_r <= elem_mem[elem_raddr];
  end

  // frequency table
  always_ff @(posedge clk) begin
    if (freq_we) begin
      freq_mem[freq_waddr] <= freq_wdata;
    end
    freq_rdata_r <= freq_mem[freq_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      ws_r        <= '0;
      we_r        <= '0;
      total_r     <= '0;
      qry_r       <= 1'b0;
      add_r       <= 1'b0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      ws_r        <= ws_nxt;
      we_r        <= we_nxt;
      total_r     <= total_nxt;
      qry_r       <= qry_nxt;
      add_r       <= add_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lft_r     <= lft_nxt;
    end_r     <= end_nxt;
    tag_r     <= tag_nxt;
    idx_r     <= idx_nxt;
    val_r     <= val_nxt;
    v_r       <= v_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_tag_r <= out_tag_nxt;
    out_bad_r <= out_bad_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.distinct_count = out_cnt_r;
  assign out_ch.answer_tag     = out_tag_r;
  assign out_ch.bad_range      = out_bad_r;

  // checks
  `RDC_ASSERT_HOLDS(a_window_order, ws_r <= we_r, "window start passed window end")
  `RDC_ASSERT_IMPLIES(a_bad_zero, out_valid_r && out_bad_r, out_cnt_r == '0, "bad range with count")
  `RDC_ASSERT_NEXT(a_query_busy, in_fire && (in_ch.opcode == rdc_pkg::OP_QUERY), state_r != S_IDLE, "query dropped")

endmodule
